>>> hdl/name_directory_sort_search_core_macros.svh
// Assertion macros for the name directory core checker.
// Needs clk and arst_n in the scope of each use.
`ifndef NAME_DIRECTORY_SORT_SEARCH_CORE_MACROS_SVH
`define NAME_DIRECTORY_SORT_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define NDSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NDSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ndss_pkg.sv
// Shared types, codes and helper functions for the name directory core.
// No dependencies.
`timescale 1ns / 1ps

package ndss_pkg;

	localparam int DEF_MAX_ENTRIES = 4096;
	localparam int DEF_STACK_DEPTH = 32;
	localparam int NAME_W          = 64;
	localparam int NAME_BYTES      = 8;
	localparam int IDX_W           = 12;
	localparam int OUT_W           = 16;
	localparam int CMD_W           = 5;

	localparam logic [7:0] CHAR_A_LO   = 8'h61;
	localparam logic [7:0] CHAR_Z_LO   = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_FINAL  = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [CMD_W-1:0] CMD_NONE    = 5'd0;
	localparam logic [CMD_W-1:0] CMD_CAPTURE = 5'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 5'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 5'd3;
	localparam logic [CMD_W-1:0] CMD_D_INIT  = 5'd4;
	localparam logic [CMD_W-1:0] CMD_D_RDI   = 5'd5;
	localparam logic [CMD_W-1:0] CMD_D_LATI  = 5'd6;
	localparam logic [CMD_W-1:0] CMD_D_CMP   = 5'd7;
	localparam logic [CMD_W-1:0] CMD_S_INIT  = 5'd8;
	localparam logic [CMD_W-1:0] CMD_S_TEST  = 5'd9;
	localparam logic [CMD_W-1:0] CMD_S_POP   = 5'd10;
	localparam logic [CMD_W-1:0] CMD_SW0     = 5'd11;
	localparam logic [CMD_W-1:0] CMD_SW1     = 5'd12;
	localparam logic [CMD_W-1:0] CMD_SW2     = 5'd13;
	localparam logic [CMD_W-1:0] CMD_SW3     = 5'd14;
	localparam logic [CMD_W-1:0] CMD_P_INIT  = 5'd15;
	localparam logic [CMD_W-1:0] CMD_P0      = 5'd16;
	localparam logic [CMD_W-1:0] CMD_P1      = 5'd17;
	localparam logic [CMD_W-1:0] CMD_P2      = 5'd18;
	localparam logic [CMD_W-1:0] CMD_PUSH    = 5'd19;
	localparam logic [CMD_W-1:0] CMD_L_INIT  = 5'd20;
	localparam logic [CMD_W-1:0] CMD_L_CMP   = 5'd21;
	localparam logic [CMD_W-1:0] CMD_B_INIT  = 5'd22;
	localparam logic [CMD_W-1:0] CMD_B0      = 5'd23;
	localparam logic [CMD_W-1:0] CMD_B1      = 5'd24;
	localparam logic [CMD_W-1:0] CMD_B2      = 5'd25;
	localparam logic [CMD_W-1:0] CMD_POST    = 5'd26;

	typedef struct packed {
		logic [CMD_W-1:0] step;
		logic             cap_pivot;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       fin;
		logic       n_lt2;
		logic       n_zero;
		logic       dd_done;
		logic       dd_ilast;
		logic       lo_lt_hi;
		logic       sp_pos;
		logic       sp_full;
		logic       i_gt_hi;
		logic       less;
		logic       key_eq;
		logic       i_zero;
		logic       cnt_zero;
		logic       out_busy;
	} status_t;

	// word 0 signed first, then word 1 signed
	function automatic logic key_less(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
		return ($signed(a[31:0]) < $signed(b[31:0])) ||
			((a[31:0] == b[31:0]) && ($signed(a[63:32]) < $signed(b[63:32])));
	endfunction

	// uppercase a..z, zero everything from the first NUL
	function automatic logic [NAME_W-1:0] make_probe(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] key;
		logic              live;
		logic [7:0]        c;
		key  = '0;
		live = 1'b1;
		for (int k = 0; k < NAME_BYTES; k++) begin
			c = raw[8*k +: 8];
			if (c == 8'h00)
				live = 1'b0;
			if (live) begin
				if (c inside {[CHAR_A_LO:CHAR_Z_LO]})
					c = c - CASE_OFFSET;
				key[8*k +: 8] = c;
			end
		end
		return key;
	endfunction

endpackage

>>> hdl/ndss_ctrl.sv
// Sequencer for the name directory core: decodes ops, steps dedupe,
// quicksort and search. Uses ndss_pkg command and status types.
`timescale 1ns / 1ps

module ndss_ctrl import ndss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    ready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DECODE = 5'd1;
	localparam logic [4:0] ST_POST   = 5'd2;
	localparam logic [4:0] ST_D_INIT = 5'd3;
	localparam logic [4:0] ST_D_RDI  = 5'd4;
	localparam logic [4:0] ST_D_LATI = 5'd5;
	localparam logic [4:0] ST_D_CMP  = 5'd6;
	localparam logic [4:0] ST_S_INIT = 5'd7;
	localparam logic [4:0] ST_S_TEST = 5'd8;
	localparam logic [4:0] ST_S_POP  = 5'd9;
	localparam logic [4:0] ST_SW0    = 5'd10;
	localparam logic [4:0] ST_SW1    = 5'd11;
	localparam logic [4:0] ST_SW2    = 5'd12;
	localparam logic [4:0] ST_SW3    = 5'd13;
	localparam logic [4:0] ST_P_INIT = 5'd14;
	localparam logic [4:0] ST_P0     = 5'd15;
	localparam logic [4:0] ST_P1     = 5'd16;
	localparam logic [4:0] ST_P2     = 5'd17;
	localparam logic [4:0] ST_PUSH   = 5'd18;
	localparam logic [4:0] ST_L_INIT = 5'd19;
	localparam logic [4:0] ST_L_CMP  = 5'd20;
	localparam logic [4:0] ST_B_INIT = 5'd21;
	localparam logic [4:0] ST_B0     = 5'd22;
	localparam logic [4:0] ST_B1     = 5'd23;
	localparam logic [4:0] ST_B2     = 5'd24;

	// where a swap returns to
	localparam logic [1:0] RET_PIV  = 2'd0;
	localparam logic [1:0] RET_NEXT = 2'd1;
	localparam logic [1:0] RET_PUSH = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_PIV;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		cmd.step      = CMD_NONE;
		cmd.cap_pivot = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.step = CMD_CAPTURE;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (st.op)
					OP_CLEAR: begin
						cmd.step = CMD_CLEAR;
						state_d  = ST_IDLE;
					end
					OP_LOAD: begin
						cmd.step = CMD_LOAD;
						state_d  = ST_POST;
					end
					OP_FINAL: state_d = ST_D_INIT;
					default:  state_d = st.fin ? ST_B_INIT : ST_L_INIT;
				endcase
			end
			ST_POST: begin
				if (!st.out_busy) begin
					cmd.step = CMD_POST;
					state_d  = ST_IDLE;
				end
			end
			ST_D_INIT: begin
				cmd.step = CMD_D_INIT;
				state_d  = st.n_lt2 ? ST_S_INIT : ST_D_RDI;
			end
			ST_D_RDI: begin
				cmd.step = CMD_D_RDI;
				state_d  = ST_D_LATI;
			end
			ST_D_LATI: begin
				cmd.step = CMD_D_LATI;
				state_d  = ST_D_CMP;
			end
			ST_D_CMP: begin
				cmd.step = CMD_D_CMP;
				if (st.dd_done)
					state_d = st.dd_ilast ? ST_S_INIT : ST_D_RDI;
			end
			ST_S_INIT: begin
				cmd.step = CMD_S_INIT;
				state_d  = ST_S_TEST;
			end
			ST_S_TEST: begin
				cmd.step = CMD_S_TEST;
				if (st.lo_lt_hi) begin
					ret_d   = RET_PIV;
					state_d = ST_SW0;
				end else begin
					state_d = st.sp_pos ? ST_S_POP : ST_IDLE;
				end
			end
			ST_S_POP: begin
				cmd.step = CMD_S_POP;
				state_d  = ST_S_TEST;
			end
			ST_SW0: begin
				cmd.step = CMD_SW0;
				state_d  = ST_SW1;
			end
			ST_SW1: begin
				cmd.step = CMD_SW1;
				state_d  = ST_SW2;
			end
			ST_SW2: begin
				cmd.step = CMD_SW2;
				state_d  = ST_SW3;
			end
			ST_SW3: begin
				cmd.step      = CMD_SW3;
				cmd.cap_pivot = (ret_q == RET_PIV);
				case (ret_q)
					RET_PIV:  state_d = ST_P_INIT;
					RET_NEXT: state_d = ST_P0;
					default:  state_d = ST_PUSH;
				endcase
			end
			ST_P_INIT: begin
				cmd.step = CMD_P_INIT;
				state_d  = ST_P0;
			end
			ST_P0: begin
				cmd.step = CMD_P0;
				if (st.i_gt_hi) begin
					ret_d   = RET_PUSH;
					state_d = ST_SW0;
				end else begin
					state_d = ST_P1;
				end
			end
			ST_P1: begin
				cmd.step = CMD_P1;
				state_d  = ST_P2;
			end
			ST_P2: begin
				cmd.step = CMD_P2;
				if (st.less) begin
					ret_d   = RET_NEXT;
					state_d = ST_SW0;
				end else begin
					state_d = ST_P0;
				end
			end
			ST_PUSH: begin
				cmd.step = CMD_PUSH;
				state_d  = st.sp_full ? ST_IDLE : ST_S_TEST;
			end
			ST_L_INIT: begin
				cmd.step = CMD_L_INIT;
				state_d  = st.n_zero ? ST_POST : ST_L_CMP;
			end
			ST_L_CMP: begin
				cmd.step = CMD_L_CMP;
				if (st.key_eq || st.i_zero)
					state_d = ST_POST;
			end
			ST_B_INIT: begin
				cmd.step = CMD_B_INIT;
				state_d  = ST_B0;
			end
			ST_B0: begin
				cmd.step = CMD_B0;
				state_d  = st.cnt_zero ? ST_POST : ST_B1;
			end
			ST_B1: begin
				cmd.step = CMD_B1;
				state_d  = ST_B2;
			end
			ST_B2: begin
				cmd.step = CMD_B2;
				state_d  = st.key_eq ? ST_POST : ST_B0;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hdl/ndss_datapath.sv
// Datapath of the name directory core: name, order and stack memories,
// sort and search registers, result and output registers. Uses ndss_pkg.
`timescale 1ns / 1ps

module ndss_datapath import ndss_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [1:0]        s_tuser,
	input  logic [NAME_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int NW  = IW + 1;
	localparam int CW  = IW + 2;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = SAW + 2;

	localparam logic signed [CW-1:0]  ZERO_S   = '0;
	localparam logic signed [CW-1:0]  ONE_S    = CW'(1);
	localparam logic signed [CW-1:0]  TWO_S    = CW'(2);
	localparam logic signed [SPW-1:0] SP_ONE   = SPW'(1);
	localparam logic signed [SPW-1:0] SP_DEPTH = SPW'(STACK_DEPTH);
	localparam logic [NW-1:0]         N_MAX    = NW'(MAX_ENTRIES);
	localparam logic [NW-1:0]         N_TWO    = NW'(2);

	logic [NAME_W-1:0] name_mem_q  [MAX_ENTRIES];
	logic [IW-1:0]     order_mem_q [MAX_ENTRIES];
	logic [2*CW-1:0]   stack_mem_q [STACK_DEPTH];

	// control state
	logic [NW-1:0] cnt_q;
	logic          fin_q;
	logic          out_valid_q;

	// working registers
	logic [1:0]            op_q;
	logic [NAME_W-1:0]     name_q, key_q, keya_q, pivot_q, nm_rd_q;
	logic [IW-1:0]         od_rd_q, sa_q, sb_q, ta_q;
	logic [2*CW-1:0]       st_rd_q;
	logic signed [CW-1:0]  lo_q, hi_q, i_q, j_q, pos_q, step_q, bcnt_q;
	logic signed [SPW-1:0] sp_q;
	logic                  res_found_q, res_ovf_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [OUT_W-1:0]      out_data_q;

	// memory ports
	logic              nm_we, od_we, st_we;
	logic [IW-1:0]     nm_raddr, nm_waddr, od_raddr, od_waddr, od_wdata;
	logic [NAME_W-1:0] nm_wdata;
	logic [SAW-1:0]    st_raddr;
	logic [2*CW-1:0]   st_wdata;

	logic signed [CW-1:0]  n_s, n_m1, i_p1, i_p2, i_m1, j_p1, j_m1, lo_p1, mid;
	logic signed [CW-1:0]  d_left, d_right, b_p, b_step0, b_cnt0, b_pos0;
	logic signed [CW-1:0]  pos_dn, pos_up, pos_nx, step_nx, bcnt_nx;
	logic signed [CW:0]    lohi_sum;
	logic signed [SPW-1:0] sp_m1, sp_p1;
	logic                  full, left_small, key_eq, probe_less;

	always_comb begin
		n_s        = $signed({1'b0, cnt_q});
		n_m1       = n_s - ONE_S;
		i_p1       = i_q + ONE_S;
		i_p2       = i_q + TWO_S;
		i_m1       = i_q - ONE_S;
		j_p1       = j_q + ONE_S;
		j_m1       = j_q - ONE_S;
		lo_p1      = lo_q + ONE_S;
		lohi_sum   = {lo_q[CW-1], lo_q} + {hi_q[CW-1], hi_q};
		mid        = lohi_sum[CW:1];
		d_left     = j_q - lo_q;
		d_right    = hi_q - j_q;
		left_small = d_left < d_right;
		sp_m1      = sp_q - SP_ONE;
		sp_p1      = sp_q + SP_ONE;
		full       = cnt_q >= N_MAX;
		key_eq     = (nm_rd_q == key_q);
		probe_less = key_less(key_q, nm_rd_q);
		// first binary probe, clamped into the table
		b_p        = (n_s + ONE_S) >>> 1;
		b_step0    = (b_p + ONE_S) >>> 1;
		b_cnt0     = b_p <<< 1;
		b_pos0     = (b_p > n_m1) ? n_m1 : b_p;
		pos_dn     = pos_q - step_q;
		pos_up     = pos_q + step_q;
		if (probe_less)
			pos_nx = (pos_dn < ZERO_S) ? ZERO_S : pos_dn;
		else
			pos_nx = (pos_up >= n_s) ? n_m1 : pos_up;
		step_nx    = (step_q + ONE_S) >>> 1;
		bcnt_nx    = bcnt_q >>> 1;
	end

	always_comb begin
		nm_we    = 1'b0;
		od_we    = 1'b0;
		st_we    = 1'b0;
		nm_raddr = '0;
		od_raddr = '0;
		nm_waddr = cnt_q[IW-1:0];
		nm_wdata = name_q;
		od_waddr = cnt_q[IW-1:0];
		od_wdata = cnt_q[IW-1:0];
		st_raddr = sp_m1[SAW-1:0];
		st_wdata = left_small ? {j_p1, hi_q} : {lo_q, j_m1};
		case (cmd.step)
			CMD_LOAD: begin
				nm_we = !full;
				od_we = !full;
			end
			CMD_D_RDI:  nm_raddr = i_q[IW-1:0];
			CMD_D_LATI: nm_raddr = i_p1[IW-1:0];
			CMD_D_CMP: begin
				nm_raddr = j_p1[IW-1:0];
				nm_we    = (nm_rd_q == keya_q);
				nm_waddr = i_q[IW-1:0];
				nm_wdata = '0;
			end
			CMD_SW0: od_raddr = sa_q;
			CMD_SW1: od_raddr = sb_q;
			CMD_SW2: begin
				od_we    = 1'b1;
				od_waddr = sa_q;
				od_wdata = od_rd_q;
				nm_raddr = od_rd_q;
			end
			CMD_SW3: begin
				od_we    = 1'b1;
				od_waddr = sb_q;
				od_wdata = ta_q;
			end
			CMD_P0:     od_raddr = i_q[IW-1:0];
			CMD_P1:     nm_raddr = od_rd_q;
			CMD_PUSH:   st_we    = 1'b1;
			CMD_L_INIT: nm_raddr = n_m1[IW-1:0];
			CMD_L_CMP:  nm_raddr = i_m1[IW-1:0];
			CMD_B0:     od_raddr = pos_q[IW-1:0];
			CMD_B1:     nm_raddr = od_rd_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nm_we)
			name_mem_q[nm_waddr] <= nm_wdata;
		nm_rd_q <= name_mem_q[nm_raddr];
	end

	always_ff @(posedge clk) begin
		if (od_we)
			order_mem_q[od_waddr] <= od_wdata;
		od_rd_q <= order_mem_q[od_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we)
			stack_mem_q[sp_q[SAW-1:0]] <= st_wdata;
		st_rd_q <= stack_mem_q[st_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (cmd.step)
				CMD_CLEAR: begin
					cnt_q <= '0;
					fin_q <= 1'b0;
				end
				CMD_LOAD: begin
					if (!full) begin
						cnt_q <= cnt_q + NW'(1);
						fin_q <= 1'b0;
					end
				end
				CMD_S_TEST: begin
					if (!(lo_q < hi_q) && !(sp_q > 0))
						fin_q <= 1'b1;
				end
				CMD_PUSH: begin
					if (sp_p1 >= SP_DEPTH)
						fin_q <= 1'b1;
				end
				CMD_POST: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.step)
			CMD_CAPTURE: begin
				op_q   <= s_tuser;
				name_q <= s_tdata;
				key_q  <= make_probe(s_tdata);
			end
			CMD_LOAD: begin
				res_found_q <= 1'b0;
				res_idx_q   <= '0;
				res_ovf_q   <= full;
			end
			CMD_D_INIT: i_q <= ZERO_S;
			CMD_D_LATI: begin
				keya_q <= nm_rd_q;
				j_q    <= i_p1;
			end
			CMD_D_CMP: begin
				if ((nm_rd_q == keya_q) || (j_q == n_m1))
					i_q <= i_p1;
				else
					j_q <= j_p1;
			end
			CMD_S_INIT: begin
				lo_q <= ZERO_S;
				hi_q <= n_m1;
				sp_q <= '0;
			end
			CMD_S_TEST: begin
				if (lo_q < hi_q) begin
					sa_q <= lo_q[IW-1:0];
					sb_q <= mid[IW-1:0];
				end else begin
					sp_q <= sp_m1;
				end
			end
			CMD_S_POP: begin
				lo_q <= st_rd_q[2*CW-1:CW];
				hi_q <= st_rd_q[CW-1:0];
			end
			CMD_SW1: ta_q <= od_rd_q;
			CMD_SW3: begin
				if (cmd.cap_pivot)
					pivot_q <= nm_rd_q;
			end
			CMD_P_INIT: begin
				j_q <= lo_q;
				i_q <= lo_p1;
			end
			CMD_P0: begin
				// partition done: final swap of pivot into place
				sa_q <= lo_q[IW-1:0];
				sb_q <= j_q[IW-1:0];
			end
			CMD_P2: begin
				i_q <= i_p1;
				if (key_less(nm_rd_q, pivot_q)) begin
					j_q  <= j_p1;
					sa_q <= i_q[IW-1:0];
					sb_q <= j_p1[IW-1:0];
				end
			end
			CMD_PUSH: begin
				if (left_small)
					hi_q <= j_m1;
				else
					lo_q <= j_p1;
				sp_q <= sp_p1;
			end
			CMD_L_INIT: begin
				i_q         <= n_m1;
				res_found_q <= 1'b0;
				res_idx_q   <= '0;
				res_ovf_q   <= 1'b0;
			end
			CMD_L_CMP: begin
				if (key_eq) begin
					res_found_q <= 1'b1;
					res_idx_q   <= IDX_W'(i_q[IW-1:0]);
				end else begin
					i_q <= i_m1;
				end
			end
			CMD_B_INIT: begin
				pos_q       <= b_pos0;
				step_q      <= b_step0;
				bcnt_q      <= b_cnt0;
				res_found_q <= 1'b0;
				res_idx_q   <= '0;
				res_ovf_q   <= 1'b0;
			end
			CMD_B1: ta_q <= od_rd_q;
			CMD_B2: begin
				if (key_eq) begin
					res_found_q <= 1'b1;
					res_idx_q   <= IDX_W'(ta_q);
				end else begin
					pos_q  <= pos_nx;
					step_q <= step_nx;
					bcnt_q <= bcnt_nx;
				end
			end
			CMD_POST: out_data_q <= {2'b00, res_ovf_q, res_idx_q, res_found_q};
			default: ;
		endcase
	end

	always_comb begin
		st.op       = op_q;
		st.fin      = fin_q;
		st.n_lt2    = cnt_q < N_TWO;
		st.n_zero   = (cnt_q == '0);
		st.dd_done  = (nm_rd_q == keya_q) || (j_q == n_m1);
		st.dd_ilast = i_p2 >= n_s;
		st.lo_lt_hi = lo_q < hi_q;
		st.sp_pos   = sp_q > 0;
		st.sp_full  = sp_p1 >= SP_DEPTH;
		st.i_gt_hi  = i_q > hi_q;
		st.less     = key_less(nm_rd_q, pivot_q);
		st.key_eq   = key_eq;
		st.i_zero   = (i_q == ZERO_S);
		st.cnt_zero = (bcnt_q == ZERO_S);
		st.out_busy = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> hdl/name_directory_sort_search_core.sv
// Name directory with dedupe, quicksort index and search.
// Top level: joins ndss_ctrl and ndss_datapath; uses ndss_pkg.
//
// Usage: one input transaction on the s_ side carries op in s_tuser and a
// name in s_tdata. Clear (op 0) and finalize (op 2) give no result; load
// (op 1) and lookup (op 3) give one result transaction on the m_ side.
// Items are handled one at a time: s_tready is high only while idle.
// A linear lookup compares entries from the last one down; a sorted lookup
// steps through binary probes, and each probe is bound by the order memory
// read followed by the name memory read and then the compare.
// Finalize is bound by the single name memory read port: dedupe compares
// pairs of names, and the sort reads names through the order memory.
// A finished result sits in the output register while the next item is
// taken; if the receiver still stalls when the next result is ready, the
// core waits with it. Reset empties the table and clears finalize and the
// output valid flag; no memory clearing pass is needed.
`timescale 1ns / 1ps

module name_directory_sort_search_core import ndss_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [NAME_W-1:0] s_tdata,  // name_low, name_high
	input  logic [1:0]        s_tuser,  // op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // found, entry_index, overflow, zero pad
);

	cmd_t    cmd;
	status_t st;

	ndss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.ready    (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ndss_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> hdl/ndss_checker.sv
// Port-level checks for the name directory core, bound to the top level.
// Uses the macros header.
`timescale 1ns / 1ps
`include "name_directory_sort_search_core_macros.svh"

module ndss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`NDSS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`NDSS_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "ready stayed high after a transaction")
	`NDSS_ASSERT_IMP(a_excl, m_tvalid, !(m_tdata[0] && m_tdata[13]), "found and overflow together")
	`NDSS_ASSERT_IMP(a_idx_zero, m_tvalid && !m_tdata[0], m_tdata[12:1] == 12'd0, "index set on a miss")

endmodule

bind name_directory_sort_search_core ndss_checker u_chk (.*);
